// File: sv/rot90_pkg.sv
// Shared constants, register map and types for the 90-degree frame rotator.
// No dependencies; imported by the interfaces, all modules and the checker.

package rot90_pkg;

  // Default largest frame edge in pixels
  localparam int unsigned MAX_DIM_DEF = 128;

  // Pixel word width
  localparam int unsigned PIX_W = 24;

  // Configuration port geometry
  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  // Register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_IMG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CCW        = 2'd2;
  localparam logic [1:0] REG_THREE_BYTE = 2'd3;

  // Register reset values
  localparam logic [7:0] RST_IMG_WIDTH  = 8'd128;
  localparam logic [7:0] RST_IMG_HEIGHT = 8'd128;
  localparam logic       RST_CCW        = 1'b0;
  localparam logic       RST_THREE_BYTE = 1'b1;

  // Operation codes on the input channel
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result queue depth and its occupancy counter width
  localparam int unsigned RES_DEPTH = 8;
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  // One result word
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } rot90_res_t;

endpackage

// File: sv/rot90_ifs.sv
// Valid/ready channel interfaces for the rotator input and output words.
// Depends on rot90_pkg for the pixel width.

interface rot90_in_if import rot90_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output operation, output pixel_in, input ready);
  modport sink   (input valid, input operation, input pixel_in, output ready);
endinterface

interface rot90_out_if import rot90_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

// File: sv/rot90_ofifo.sv
// Small result queue between the frame store read and the output channel.
// Depends on rot90_pkg for the result word type.

module rot90_ofifo import rot90_pkg::*; #(
  parameter int unsigned DEPTH = RES_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  rot90_res_t push_data_i,
  input  logic       pop_i,
  output logic       valid_o,
  output rot90_res_t data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rot90_res_t       entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_pop;

  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CNT_W'(push_i) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold result words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: sv/image_rotate_90_unit.sv
// Rotates a frame by 90 degrees: load words fill the frame store in raster order, read words
// return the rotated frame in raster order with the final pixel marked. The block takes one
// word per clock in each direction unless stalled; a read word passes through the three-stage
// path of counter update, address multiply and frame store access, then the result queue.
// Up to RES_DEPTH reads may be outstanding; beyond that the input stalls until results are
// taken. The frame store is one single-port memory of MAX_DIM*MAX_DIM words with a registered
// read; it needs no clearing pass, so the block is ready right after reset. Load a whole frame
// before reading it.

module image_rotate_90_unit import rot90_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rot90_in_if.sink          in_i,
  rot90_out_if.source       out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned ROW_W   = $clog2(MAX_DIM);
  localparam int unsigned DEPTH   = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned TOT_W   = $clog2(DEPTH + 1);
  localparam int unsigned PROD_W  = 2 * DIM_W;
  localparam int unsigned RST_W   = (int'(RST_IMG_WIDTH) > MAX_DIM) ? MAX_DIM
                                                                    : int'(RST_IMG_WIDTH);
  localparam int unsigned RST_H   = (int'(RST_IMG_HEIGHT) > MAX_DIM) ? MAX_DIM
                                                                     : int'(RST_IMG_HEIGHT);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [7:0] v);
    logic [DIM_W-1:0] r;
    if (v == 8'd0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- configuration
  logic [7:0]       img_width_q, img_height_q;
  logic             ccw_q, three_byte_q;
  logic [DIM_W-1:0] w_q, h_q, w_new, h_new, mul_l, mul_r;
  logic [TOT_W-1:0] total_q;
  logic             cfg_we;
  logic [1:0]       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];
  assign w_new   = clamp_dim(pwdata[7:0]);
  assign h_new   = clamp_dim(pwdata[7:0]);
  assign mul_l   = (cfg_idx == REG_IMG_WIDTH)  ? w_new : w_q;
  assign mul_r   = (cfg_idx == REG_IMG_HEIGHT) ? h_new : h_q;

  // Write registers; keep clamped dimensions and the pixel count alongside
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q  <= RST_IMG_WIDTH;
      img_height_q <= RST_IMG_HEIGHT;
      ccw_q        <= RST_CCW;
      three_byte_q <= RST_THREE_BYTE;
      w_q          <= DIM_W'(RST_W);
      h_q          <= DIM_W'(RST_H);
      total_q      <= TOT_W'(RST_W * RST_H);
    end else if (cfg_we) begin
      total_q <= TOT_W'(PROD_W'(mul_l) * PROD_W'(mul_r));
      unique case (cfg_idx)
        REG_IMG_WIDTH: begin
          img_width_q <= pwdata[7:0];
          w_q         <= w_new;
        end
        REG_IMG_HEIGHT: begin
          img_height_q <= pwdata[7:0];
          h_q          <= h_new;
        end
        REG_CCW:        ccw_q        <= pwdata[0];
        REG_THREE_BYTE: three_byte_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back registers
  always_comb begin
    unique case (cfg_idx)
      REG_IMG_WIDTH:  prdata = CFG_DW'(img_width_q);
      REG_IMG_HEIGHT: prdata = CFG_DW'(img_height_q);
      REG_CCW:        prdata = CFG_DW'(ccw_q);
      REG_THREE_BYTE: prdata = CFG_DW'(three_byte_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- accept stage
  logic [RES_CNT_W-1:0] pend_q, pend_d;
  logic                 in_acc, rd_acc, out_pop;
  logic [ADDR_W-1:0]    load_idx_q, load_idx_d, ld_eff;
  logic [TOT_W-1:0]     ld_next;
  logic [ROW_W-1:0]     row_q, row_d, col_q, col_d, row_eff, col_eff;
  logic [DIM_W-1:0]     row_inc, col_inc;
  logic                 at_last;

  assign in_i.ready = (pend_q < RES_CNT_W'(RES_DEPTH));
  assign in_acc     = in_i.valid && in_i.ready;
  assign rd_acc     = in_acc && (in_i.operation == OP_READ);
  assign out_pop    = out_o.valid && out_o.ready;
  assign pend_d     = pend_q + RES_CNT_W'(rd_acc) - RES_CNT_W'(out_pop);

  // Restart counters that fall outside the current frame
  always_comb begin
    ld_eff  = (TOT_W'(load_idx_q) >= total_q) ? '0 : load_idx_q;
    ld_next = TOT_W'(ld_eff) + 1'b1;
    if ((DIM_W'(row_q) >= w_q) || (DIM_W'(col_q) >= h_q)) begin
      row_eff = '0;
      col_eff = '0;
    end else begin
      row_eff = row_q;
      col_eff = col_q;
    end
    row_inc = DIM_W'(row_eff) + 1'b1;
    col_inc = DIM_W'(col_eff) + 1'b1;
    at_last = (row_inc == w_q) && (col_inc == h_q);
  end

  // Advance load index and output raster position
  always_comb begin
    load_idx_d = load_idx_q;
    row_d      = row_q;
    col_d      = col_q;
    if (in_acc) begin
      if (in_i.operation == OP_LOAD) begin
        load_idx_d = (ld_next >= total_q) ? '0 : ADDR_W'(ld_next);
      end else begin
        row_d = row_eff;
        col_d = ROW_W'(col_inc);
        if (col_inc >= h_q) begin
          col_d = '0;
          row_d = (row_inc >= w_q) ? '0 : ROW_W'(row_inc);
        end
      end
    end
  end

  logic              p1_valid_q, p1_op_q, p1_last_q;
  logic [PIX_W-1:0]  p1_pix_q;
  logic [ADDR_W-1:0] p1_ld_addr_q;
  logic [DIM_W-1:0]  p1_mul_a_q, p1_add_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      load_idx_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
      p1_valid_q <= 1'b0;
    end else begin
      pend_q     <= pend_d;
      load_idx_q <= load_idx_d;
      row_q      <= row_d;
      col_q      <= col_d;
      p1_valid_q <= in_acc;
    end
  end

  // Capture operands for the address multiply
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p1_op_q      <= in_i.operation;
      p1_pix_q     <= in_i.pixel_in;
      p1_last_q    <= at_last;
      p1_ld_addr_q <= ld_eff;
      if (ccw_q) begin
        p1_mul_a_q <= DIM_W'(col_eff);
        p1_add_b_q <= w_q - 1'b1 - DIM_W'(row_eff);
      end else begin
        p1_mul_a_q <= h_q - 1'b1 - DIM_W'(col_eff);
        p1_add_b_q <= DIM_W'(row_eff);
      end
    end
  end

  // ---------------------------------------------------------------- address stage
  logic              p2_valid_q, p2_op_q, p2_last_q;
  logic [PIX_W-1:0]  p2_pix_q;
  logic [ADDR_W-1:0] p2_addr_q;
  logic [PROD_W-1:0] rd_prod;

  assign rd_prod = p1_mul_a_q * w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else begin
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_valid_q) begin
      p2_op_q   <= p1_op_q;
      p2_pix_q  <= p1_pix_q;
      p2_last_q <= p1_last_q;
      p2_addr_q <= (p1_op_q == OP_READ) ? ADDR_W'(rd_prod + PROD_W'(p1_add_b_q))
                                        : p1_ld_addr_q;
    end
  end

  // ---------------------------------------------------------------- frame store
  logic [PIX_W-1:0] frame_mem [DEPTH];
  logic [PIX_W-1:0] rd_data_q;
  logic             p3_valid_q, p3_last_q;

  always_ff @(posedge clk_i) begin
    if (p2_valid_q && (p2_op_q == OP_LOAD)) begin
      frame_mem[p2_addr_q] <= p2_pix_q;
    end
    rd_data_q <= frame_mem[p2_addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_valid_q <= 1'b0;
    end else begin
      p3_valid_q <= p2_valid_q && (p2_op_q == OP_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    p3_last_q <= p2_last_q;
  end

  // ---------------------------------------------------------------- result queue
  rot90_res_t push_data, head;
  logic       head_valid;

  // Drop upper bytes for 8-bit pixels
  always_comb begin
    push_data.pixel = three_byte_q ? rd_data_q : {{(PIX_W - 8){1'b0}}, rd_data_q[7:0]};
    push_data.last  = p3_last_q;
  end

  rot90_ofifo #(
    .DEPTH (RES_DEPTH)
  ) u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (p3_valid_q),
    .push_data_i (push_data),
    .pop_i       (out_o.ready),
    .valid_o     (head_valid),
    .data_o      (head)
  );

  assign out_o.valid      = head_valid;
  assign out_o.pixel_out  = head.pixel;
  assign out_o.frame_last = head.last;

endmodule

// File: sv/rot90_chk.sv
// Port-level checker for the rotator, bound to image_rotate_90_unit.
// Depends on rot90_pkg for the result queue depth and register indexes.

module rot90_chk import rot90_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              in_operation_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [PIX_W-1:0]  out_pixel_i,
  input logic              out_last_i,
  input logic              psel_i,
  input logic              penable_i,
  input logic              pwrite_i,
  input logic [CFG_AW-1:0] paddr_i,
  input logic [CFG_DW-1:0] pwdata_i
);

  logic [RES_CNT_W-1:0] pend_q;
  logic                 three_byte_q;
  logic                 rd_acc, out_pop;

  assign rd_acc  = in_valid_i && in_ready_i && (in_operation_i == OP_READ);
  assign out_pop = out_valid_i && out_ready_i;

  // Track reads still owed a result and the pixel size setting
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= '0;
      three_byte_q <= RST_THREE_BYTE;
    end else begin
      pend_q <= pend_q + RES_CNT_W'(rd_acc) - RES_CNT_W'(out_pop);
      if (psel_i && penable_i && pwrite_i && (paddr_i[3:2] == REG_THREE_BYTE)) begin
        three_byte_q <= pwdata_i[0];
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_pixel_i) && $stable(out_last_i))
    else $error("result word changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pend_q != '0))
    else $error("result word without an outstanding read");

  a_ready_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (pend_q < RES_CNT_W'(RES_DEPTH)))
    else $error("input ready does not follow outstanding read count");

  a_byte_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !three_byte_q |-> (out_pixel_i[PIX_W-1:8] == '0))
    else $error("upper bytes set on an 8-bit pixel");

endmodule

bind image_rotate_90_unit rot90_chk u_rot90_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_operation_i (in_i.operation),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_pixel_i    (out_o.pixel_out),
  .out_last_i     (out_o.frame_last),
  .psel_i         (psel),
  .penable_i      (penable),
  .pwrite_i       (pwrite),
  .paddr_i        (paddr),
  .pwdata_i       (pwdata)
);
